// ===== design/svp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package svp_pkg;

	// Default position counter width
	localparam int POSITION_BITS_DEF = 10;

	// Configuration port geometry
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 10;

	// Command codes
	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_SET     = 3'd1;
	localparam logic [2:0] CMD_PARK    = 3'd2;
	localparam logic [2:0] CMD_COMP    = 3'd3;
	localparam logic [2:0] CMD_HOME    = 3'd4;

	// Register indexes
	localparam logic [2:0] REG_STEP_INTERVAL = 3'd0;
	localparam logic [2:0] REG_HOME_STEPS    = 3'd1;
	localparam logic [2:0] REG_MAX_POSITION  = 3'd2;
	localparam logic [2:0] REG_PARK_POSITION = 3'd3;
	localparam logic [2:0] REG_START_TARGET  = 3'd4;
	localparam logic [2:0] REG_AC_BUMP       = 3'd5;
	localparam logic [2:0] REG_STEERING_BUMP = 3'd6;
	localparam logic [2:0] REG_DRIVE_BUMP    = 3'd7;

	// Register reset values
	localparam logic [7:0] RST_STEP_INTERVAL = 8'd10;
	localparam logic [9:0] RST_HOME_STEPS    = 10'd220;
	localparam logic [9:0] RST_MAX_POSITION  = 10'd200;
	localparam logic [9:0] RST_PARK_POSITION = 10'd30;
	localparam logic [9:0] RST_START_TARGET  = 10'd50;

	localparam logic [7:0] TICKS_MAX = 8'hFF;
	localparam logic [3:0] COILS_OFF = 4'h0;

	typedef struct packed {
		logic [7:0] step_interval;
		logic [9:0] home_steps;
		logic [9:0] max_position;
		logic [9:0] park_position;
		logic [9:0] start_target;
		logic [7:0] ac_bump;
		logic [7:0] steering_bump;
		logic [7:0] drive_bump;
	} cfg_t;

	// Drive state that does not depend on the position width
	typedef struct packed {
		logic [1:0] phase;
		logic [7:0] elapsed;
		logic [9:0] home_left;
		logic       homing;
		logic [3:0] coil;
	} ctl_t;

	// Full-step coil patterns: A+B+, A-B+, A-B-, A+B-
	function automatic logic [3:0] phase_coils(input logic [1:0] ph);
		logic [3:0] c;
		case (ph)
			2'd0:    c = 4'hA;
			2'd1:    c = 4'h6;
			2'd2:    c = 4'h5;
			default: c = 4'h9;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== design/svp_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module svp_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [svp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [svp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output svp_pkg::cfg_t                           cfg
);

	svp_pkg::cfg_t cfg_q;

	// Register file, one write per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_interval <= svp_pkg::RST_STEP_INTERVAL;
			cfg_q.home_steps    <= svp_pkg::RST_HOME_STEPS;
			cfg_q.max_position  <= svp_pkg::RST_MAX_POSITION;
			cfg_q.park_position <= svp_pkg::RST_PARK_POSITION;
			cfg_q.start_target  <= svp_pkg::RST_START_TARGET;
			cfg_q.ac_bump       <= '0;
			cfg_q.steering_bump <= '0;
			cfg_q.drive_bump    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				svp_pkg::REG_STEP_INTERVAL: cfg_q.step_interval <= cfg_data[7:0];
				svp_pkg::REG_HOME_STEPS:    cfg_q.home_steps    <= cfg_data;
				svp_pkg::REG_MAX_POSITION:  cfg_q.max_position  <= cfg_data;
				svp_pkg::REG_PARK_POSITION: cfg_q.park_position <= cfg_data;
				svp_pkg::REG_START_TARGET:  cfg_q.start_target  <= cfg_data;
				svp_pkg::REG_AC_BUMP:       cfg_q.ac_bump       <= cfg_data[7:0];
				svp_pkg::REG_STEERING_BUMP: cfg_q.steering_bump <= cfg_data[7:0];
				svp_pkg::REG_DRIVE_BUMP:    cfg_q.drive_bump    <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== design/svp_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Next-state logic for one command
module svp_step #(
	parameter int POSITION_BITS = svp_pkg::POSITION_BITS_DEF
) (
	input  svp_pkg::cfg_t             cfg,
	input  wire logic [2:0]           command,
	input  wire logic signed [15:0]   target_value,
	input  wire logic                 ac_on,
	input  wire logic                 steering_load,
	input  wire logic                 drive_gear,
	input  svp_pkg::ctl_t             ctl,
	input  wire logic [POSITION_BITS-1:0] pos,
	input  wire logic [POSITION_BITS-1:0] tgt,
	output svp_pkg::ctl_t             ctl_d,
	output logic [POSITION_BITS-1:0]  pos_d,
	output logic [POSITION_BITS-1:0]  tgt_d,
	output logic                      stepped
);

	// Wide enough for a signed request or target plus all bumps
	localparam int SW = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 2;
	localparam logic signed [SW-1:0] POS_LIM = SW'(2**POSITION_BITS - 1);

	function automatic logic signed [SW-1:0] limit_pos(input logic signed [SW-1:0] v);
		return (v > POS_LIM) ? POS_LIM : v;
	endfunction

	function automatic logic [POSITION_BITS-1:0] clamp(input logic signed [SW-1:0] v,
		input logic signed [SW-1:0] hi);
		logic signed [SW-1:0] r;
		if (v < 0)
			r = '0;
		else if (v > hi)
			r = hi;
		else
			r = v;
		return r[POSITION_BITS-1:0];
	endfunction

	logic signed [SW-1:0] hi_lim;
	logic signed [SW-1:0] start_lim;
	logic signed [SW-1:0] comp_sum;
	logic [POSITION_BITS-1:0] set_tgt, park_tgt, comp_tgt;
	logic [7:0] e_inc;
	logic       expired;
	logic [1:0] ph_fwd, ph_rev;

	// Target candidates
	always_comb begin
		hi_lim    = limit_pos(SW'(cfg.max_position));
		start_lim = limit_pos(SW'(cfg.start_target));
		comp_sum  = SW'(tgt)
			+ (ac_on         ? SW'(cfg.ac_bump)       : '0)
			+ (steering_load ? SW'(cfg.steering_bump) : '0)
			+ (drive_gear    ? SW'(cfg.drive_bump)    : '0);
		set_tgt  = clamp(SW'(target_value), hi_lim);
		park_tgt = clamp(SW'(cfg.park_position), hi_lim);
		comp_tgt = clamp(comp_sum, hi_lim);
	end

	// Interval timer
	assign e_inc   = (ctl.elapsed != svp_pkg::TICKS_MAX) ? ctl.elapsed + 8'd1 : ctl.elapsed;
	assign expired = (e_inc >= cfg.step_interval);
	assign ph_fwd  = ctl.phase + 2'd1;
	assign ph_rev  = ctl.phase - 2'd1;

	// Command decode and state update
	always_comb begin
		ctl_d   = ctl;
		pos_d   = pos;
		tgt_d   = tgt;
		stepped = 1'b0;
		if (command == svp_pkg::CMD_TICK) begin
			ctl_d.elapsed = expired ? 8'd0 : e_inc;
			if (expired) begin
				if (ctl.homing) begin
					if (ctl.home_left != 10'd0) begin
						ctl_d.phase     = ph_rev;
						ctl_d.coil      = svp_pkg::phase_coils(ph_rev);
						ctl_d.home_left = ctl.home_left - 10'd1;
						stepped         = 1'b1;
					end else begin
						ctl_d.coil   = svp_pkg::COILS_OFF;
						ctl_d.homing = 1'b0;
						pos_d        = '0;
						tgt_d        = start_lim[POSITION_BITS-1:0];
					end
				end else if (pos == tgt) begin
					ctl_d.coil = svp_pkg::COILS_OFF;
				end else if (pos < tgt) begin
					ctl_d.phase = ph_fwd;
					ctl_d.coil  = svp_pkg::phase_coils(ph_fwd);
					pos_d       = pos + POSITION_BITS'(1);
					stepped     = 1'b1;
				end else begin
					ctl_d.phase = ph_rev;
					ctl_d.coil  = svp_pkg::phase_coils(ph_rev);
					pos_d       = pos - POSITION_BITS'(1);
					stepped     = 1'b1;
				end
			end
		end else if (!ctl.homing) begin
			case (command)
				svp_pkg::CMD_SET:  tgt_d = set_tgt;
				svp_pkg::CMD_PARK: tgt_d = park_tgt;
				svp_pkg::CMD_COMP: tgt_d = comp_tgt;
				svp_pkg::CMD_HOME: begin
					ctl_d.coil      = svp_pkg::COILS_OFF;
					ctl_d.phase     = 2'd0;
					ctl_d.elapsed   = 8'd0;
					ctl_d.home_left = cfg.home_steps;
					ctl_d.homing    = 1'b1;
					pos_d           = '0;
					tgt_d           = '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/stepper_valve_positioner_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Full-step valve positioner. Each transfer on the input channel is one
// command (tick, set target, park, compensate, home) and gives exactly one
// result: coil drive, position and target after the command, the homing flag
// and whether a step was taken. One command is taken every cycle unless the
// input stalls; a command waits in the input register, and the drive state is
// updated as it moves into the result register, where its result is presented.
// The input stalls only while both the input and the result register hold a
// command and out_ready is low. The user must write configuration through a
// plain write port only while no command is in flight; the block itself does
// not enforce this.
module stepper_valve_positioner_unit #(
	parameter int POSITION_BITS = svp_pkg::POSITION_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [svp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [svp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [2:0]                         command,
	input  wire logic signed [15:0]                 target_value,
	input  wire logic                               ac_on,
	input  wire logic                               steering_load,
	input  wire logic                               drive_gear,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [3:0]                              coil_pattern,
	output logic [POSITION_BITS-1:0]                position,
	output logic [POSITION_BITS-1:0]                target,
	output logic                                    homing,
	output logic                                    stepped
);

	svp_pkg::cfg_t cfg;

	// Input register
	logic               valid_s1;
	logic [2:0]         command_s1;
	logic signed [15:0] target_value_s1;
	logic               ac_on_s1, steering_load_s1, drive_gear_s1;

	// Drive state
	svp_pkg::ctl_t            ctl_q, ctl_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d, tgt_q, tgt_d;
	logic                     stepped_d;

	// Result register
	logic                     valid_s2;
	logic [3:0]               coil_s2;
	logic [POSITION_BITS-1:0] pos_s2, tgt_s2;
	logic                     homing_s2, stepped_s2;

	logic advance;

	svp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	svp_step #(
		.POSITION_BITS (POSITION_BITS)
	) u_step (
		.cfg           (cfg),
		.command       (command_s1),
		.target_value  (target_value_s1),
		.ac_on         (ac_on_s1),
		.steering_load (steering_load_s1),
		.drive_gear    (drive_gear_s1),
		.ctl           (ctl_q),
		.pos           (pos_q),
		.tgt           (tgt_q),
		.ctl_d         (ctl_d),
		.pos_d         (pos_d),
		.tgt_d         (tgt_d),
		.stepped       (stepped_d)
	);

	// Flow control: the input register moves on whenever the result slot frees
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1       <= command;
			target_value_s1  <= target_value;
			ac_on_s1         <= ac_on;
			steering_load_s1 <= steering_load;
			drive_gear_s1    <= drive_gear;
		end
	end

	// State update, taken as the command moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
			pos_q <= '0;
			tgt_q <= '0;
		end else if (valid_s1 && advance) begin
			ctl_q <= ctl_d;
			pos_q <= pos_d;
			tgt_q <= tgt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			coil_s2    <= ctl_d.coil;
			pos_s2     <= pos_d;
			tgt_s2     <= tgt_d;
			homing_s2  <= ctl_d.homing;
			stepped_s2 <= stepped_d;
		end
	end

	assign out_valid    = valid_s2;
	assign coil_pattern = coil_s2;
	assign position     = pos_s2;
	assign target       = tgt_s2;
	assign homing       = homing_s2;
	assign stepped      = stepped_s2;

	// An empty result slot never holds off the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with empty result register");

	// The tracked position stays at zero during a homing run
	a_homing_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && homing_s2) |-> (pos_s2 == '0))
		else $error("position moved during homing");

	// A step always leaves the coils energised
	a_step_drives_coils: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && stepped_s2) |-> (coil_s2 != svp_pkg::COILS_OFF))
		else $error("step reported with coils off");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int PB           = svp_pkg::POSITION_BITS_DEF;
	localparam int CYCLE_NS     = 20;
	localparam int RANDOM_ITEMS = 1550;
	// Idle cycles after the last result to cover any slack
	localparam int DRAIN_CYCLES = 8;
	localparam int RUN_LIMIT_NS = 20_000_000;

	// Codes the block treats as no-ops
	localparam logic [2:0] CMD_RSVD_A = 3'd5;
	localparam logic [2:0] CMD_RSVD_B = 3'd6;
	localparam logic [2:0] CMD_RSVD_C = 3'd7;

	// Random settings phases with fixed shapes
	localparam int PHASE_LOW_CORNER  = 0;
	localparam int PHASE_HIGH_CORNER = 1;
	localparam int PHASE_LONG_HOME   = 2;

	typedef struct packed {
		logic [3:0]    coils;
		logic [PB-1:0] pos;
		logic [PB-1:0] tgt;
		logic          homing;
		logic          stepped;
	} valve_reading_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB, RX_CHOKED} rx_mode_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                cfg_we        = 1'b0;
	logic [2:0]          cfg_index     = '0;
	logic [9:0]          cfg_data      = '0;
	logic                in_valid      = 1'b0;
	logic [2:0]          command       = svp_pkg::CMD_TICK;
	logic signed [15:0]  target_value  = '0;
	logic                ac_on         = 1'b0;
	logic                steering_load = 1'b0;
	logic                drive_gear    = 1'b0;
	logic                out_ready     = 1'b0;

	wire                 in_ready;
	wire                 out_valid;
	wire [3:0]           coil_pattern;
	wire [PB-1:0]        position;
	wire [PB-1:0]        target;
	wire                 homing;
	wire                 stepped;

	stepper_valve_positioner_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.target_value  (target_value),
		.ac_on         (ac_on),
		.steering_load (steering_load),
		.drive_gear    (drive_gear),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.coil_pattern  (coil_pattern),
		.position      (position),
		.target        (target),
		.homing        (homing),
		.stepped       (stepped)
	);

	// Predicted valve state and settings
	svp_pkg::cfg_t valve_cfg;
	logic [1:0]    phase_ix;
	logic [PB-1:0] pos_now;
	logic [PB-1:0] tgt_now;
	logic [7:0]    tick_count;
	logic [9:0]    home_left;
	logic          home_run;
	logic [3:0]    coil_now;

	valve_reading_t due_readings[$];
	int             fail_count = 0;
	int             burst_left = 0;
	rx_mode_t       rx_mode    = RX_OPEN;
	logic [5:0]     rx_count   = '0;

	always begin
		#(CYCLE_NS / 2) clk = 1'b1;
		#(CYCLE_NS / 2) clk = 1'b0;
	end

	// Full-step sequence: A+B+, A-B+, A-B-, A+B-
	function automatic logic [3:0] coils_for(logic [1:0] ph);
		case (ph)
			2'd0:    return 4'hA;
			2'd1:    return 4'h6;
			2'd2:    return 4'h5;
			default: return 4'h9;
		endcase
	endfunction

	// Target requests land in 0..max_position; with 10 position bits the
	// register width already bounds it to the position range
	function automatic logic [PB-1:0] clamp_request(int request);
		int top;
		top = int'(valve_cfg.max_position);
		if (request < 0)
			request = 0;
		if (request > top)
			request = top;
		return request[PB-1:0];
	endfunction

	// Apply one command to the predicted state, return the reading after it
	function automatic valve_reading_t advance_valve(logic [2:0] cmd,
			logic signed [15:0] value, logic ac, logic steer, logic drv);
		valve_reading_t r;
		logic           took_step;
		int             sum;
		took_step = 1'b0;
		if (cmd == svp_pkg::CMD_TICK) begin
			if (tick_count != svp_pkg::TICKS_MAX)
				tick_count = tick_count + 8'd1;
			if (tick_count >= valve_cfg.step_interval) begin
				tick_count = '0;
				if (home_run) begin
					if (home_left != 0) begin
						phase_ix  = phase_ix - 2'd1;
						coil_now  = coils_for(phase_ix);
						home_left = home_left - 10'd1;
						took_step = 1'b1;
					end else begin
						coil_now = svp_pkg::COILS_OFF;
						pos_now  = '0;
						tgt_now  = valve_cfg.start_target;
						home_run = 1'b0;
					end
				end else if (pos_now == tgt_now) begin
					coil_now = svp_pkg::COILS_OFF;
				end else begin
					if (pos_now < tgt_now) begin
						phase_ix = phase_ix + 2'd1;
						pos_now  = pos_now + 1'b1;
					end else begin
						phase_ix = phase_ix - 2'd1;
						pos_now  = pos_now - 1'b1;
					end
					coil_now  = coils_for(phase_ix);
					took_step = 1'b1;
				end
			end
		end else if (!home_run) begin
			case (cmd)
				svp_pkg::CMD_SET: tgt_now = clamp_request(int'(value));
				svp_pkg::CMD_PARK: tgt_now = clamp_request(int'(valve_cfg.park_position));
				svp_pkg::CMD_COMP: begin
					sum = int'(tgt_now);
					if (ac)
						sum += int'(valve_cfg.ac_bump);
					if (steer)
						sum += int'(valve_cfg.steering_bump);
					if (drv)
						sum += int'(valve_cfg.drive_bump);
					tgt_now = clamp_request(sum);
				end
				svp_pkg::CMD_HOME: begin
					coil_now   = svp_pkg::COILS_OFF;
					phase_ix   = '0;
					pos_now    = '0;
					tgt_now    = '0;
					tick_count = '0;
					home_left  = valve_cfg.home_steps;
					home_run   = 1'b1;
				end
				default: ;
			endcase
		end
		r.coils   = coil_now;
		r.pos     = pos_now;
		r.tgt     = tgt_now;
		r.homing  = home_run;
		r.stepped = took_step;
		return r;
	endfunction

	task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Check each result transfer against the oldest prediction, then predict
	// for a command transferred at the same edge
	always @(posedge clk) begin : scoreboard
		valve_reading_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_readings.size() == 0) begin
					$display("%0t: unexpected result, expected none, got coils %h pos %0d tgt %0d",
						$time, coil_pattern, position, target);
					fail_count++;
				end else begin
					want = due_readings.pop_front();
					compare_field("coil_pattern", want.coils, coil_pattern);
					compare_field("position", want.pos, position);
					compare_field("target", want.tgt, target);
					compare_field("homing", want.homing, homing);
					compare_field("stepped", want.stepped, stepped);
				end
			end
			if (in_valid && in_ready)
				due_readings.push_back(advance_valve(command, target_value, ac_on,
					steering_load, drive_gear));
		end
	end

	// Receiver backpressure: a new stall mode each time the 6-bit counter wraps
	always @(posedge clk) begin
		rx_count <= rx_count + 6'd1;
		if (rx_count == '0)
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_OPEN:  out_ready <= 1'b1;
			RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
			RX_COMB:  out_ready <= (rx_count[1:0] == 2'd0);
			default:  out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// One command transfer; bursts of random length with random gaps between
	task automatic send_command(logic [2:0] cmd, logic signed [15:0] value,
			logic ac, logic steer, logic drv);
		int gap;
		in_valid      <= 1'b1;
		command       <= cmd;
		target_value  <= value;
		ac_on         <= ac;
		steering_load <= steer;
		drive_gear    <= drv;
		do @(posedge clk); while (!in_ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if ($urandom_range(0, 15) == 0)
				gap = 20;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop sending and let every outstanding result come out
	task automatic settle_block();
		in_valid <= 1'b0;
		while (due_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [9:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			svp_pkg::REG_STEP_INTERVAL: valve_cfg.step_interval = data[7:0];
			svp_pkg::REG_HOME_STEPS:    valve_cfg.home_steps    = data;
			svp_pkg::REG_MAX_POSITION:  valve_cfg.max_position  = data;
			svp_pkg::REG_PARK_POSITION: valve_cfg.park_position = data;
			svp_pkg::REG_START_TARGET:  valve_cfg.start_target  = data;
			svp_pkg::REG_AC_BUMP:       valve_cfg.ac_bump       = data[7:0];
			svp_pkg::REG_STEERING_BUMP: valve_cfg.steering_bump = data[7:0];
			default:                    valve_cfg.drive_bump    = data[7:0];
		endcase
		@(posedge clk);
	endtask

	// Write all registers while idle; 8-bit registers get junk in the top bits
	task automatic apply_config(svp_pkg::cfg_t c);
		logic [1:0] junk;
		settle_block();
		junk = 2'($urandom);
		write_reg(svp_pkg::REG_STEP_INTERVAL, {junk, c.step_interval});
		write_reg(svp_pkg::REG_HOME_STEPS, c.home_steps);
		write_reg(svp_pkg::REG_MAX_POSITION, c.max_position);
		write_reg(svp_pkg::REG_PARK_POSITION, c.park_position);
		write_reg(svp_pkg::REG_START_TARGET, c.start_target);
		junk = 2'($urandom);
		write_reg(svp_pkg::REG_AC_BUMP, {junk, c.ac_bump});
		junk = 2'($urandom);
		write_reg(svp_pkg::REG_STEERING_BUMP, {junk, c.steering_bump});
		junk = 2'($urandom);
		write_reg(svp_pkg::REG_DRIVE_BUMP, {junk, c.drive_bump});
		cfg_we <= 1'b0;
	endtask

	// Reset settings: clamps at both ends, park, empty compensation, no-op codes
	task automatic test_commands();
		send_command(svp_pkg::CMD_TICK, 16'sh0000, 1'b0, 1'b0, 1'b0);
		send_command(svp_pkg::CMD_SET, 16'sh7FFF, 1'b0, 1'b0, 1'b0);
		send_command(svp_pkg::CMD_SET, 16'sh8000, 1'b1, 1'b1, 1'b1);
		send_command(svp_pkg::CMD_SET, 16'sd201, 1'b0, 1'b0, 1'b0);
		send_command(svp_pkg::CMD_PARK, 16'shFFFF, 1'b0, 1'b0, 1'b0);
		send_command(svp_pkg::CMD_COMP, 16'sh0000, 1'b1, 1'b1, 1'b1);
		send_command(CMD_RSVD_A, 16'sh5555, 1'b1, 1'b0, 1'b1);
		send_command(CMD_RSVD_B, 16'shAAAA, 1'b0, 1'b1, 1'b0);
		send_command(CMD_RSVD_C, 16'sh7FFF, 1'b1, 1'b1, 1'b1);
	endtask

	// Bumps alone and together, overflow clamp, zero interval, zero max
	task automatic test_load_compensation();
		svp_pkg::cfg_t c;
		c = '{step_interval: 8'd0, home_steps: 10'd220, max_position: 10'd1023,
			park_position: 10'd1023, start_target: 10'd50, ac_bump: 8'd255,
			steering_bump: 8'd1, drive_bump: 8'd128};
		apply_config(c);
		send_command(svp_pkg::CMD_SET, 16'sd1000, 1'b0, 1'b0, 1'b0);
		send_command(svp_pkg::CMD_COMP, 16'sh0000, 1'b1, 1'b0, 1'b0);
		send_command(svp_pkg::CMD_SET, 16'sd0, 1'b0, 1'b0, 1'b0);
		send_command(svp_pkg::CMD_COMP, 16'sh0000, 1'b0, 1'b1, 1'b0);
		send_command(svp_pkg::CMD_COMP, 16'sh0000, 1'b0, 1'b0, 1'b1);
		send_command(svp_pkg::CMD_COMP, 16'sh0000, 1'b1, 1'b1, 1'b1);
		send_command(svp_pkg::CMD_TICK, 16'sh0000, 1'b0, 1'b0, 1'b0);
		send_command(svp_pkg::CMD_TICK, 16'sh0000, 1'b0, 1'b0, 1'b0);
		c.max_position = 10'd0;
		apply_config(c);
		send_command(svp_pkg::CMD_SET, 16'sd500, 1'b0, 1'b0, 1'b0);
		send_command(svp_pkg::CMD_PARK, 16'sh0000, 1'b0, 1'b0, 1'b0);
		send_command(svp_pkg::CMD_COMP, 16'sh0000, 1'b1, 1'b1, 1'b1);
		send_command(svp_pkg::CMD_TICK, 16'sh0000, 1'b0, 1'b0, 1'b0);
	endtask

	// Homing run with commands ignored on the way, then a run of zero steps
	task automatic test_homing();
		svp_pkg::cfg_t c;
		c = '{step_interval: 8'd1, home_steps: 10'd2, max_position: 10'd1,
			park_position: 10'd1, start_target: 10'd1023, ac_bump: 8'd3,
			steering_bump: 8'd3, drive_bump: 8'd3};
		apply_config(c);
		send_command(svp_pkg::CMD_SET, 16'sd1, 1'b0, 1'b0, 1'b0);
		send_command(svp_pkg::CMD_HOME, 16'sh0000, 1'b0, 1'b0, 1'b0);
		send_command(svp_pkg::CMD_SET, 16'sd1, 1'b0, 1'b0, 1'b0);
		send_command(svp_pkg::CMD_COMP, 16'sh0000, 1'b1, 1'b1, 1'b1);
		send_command(svp_pkg::CMD_HOME, 16'sh0000, 1'b0, 1'b0, 1'b0);
		repeat (4) send_command(svp_pkg::CMD_TICK, 16'sh0000, 1'b0, 1'b0, 1'b0);
		c.home_steps = 10'd0;
		apply_config(c);
		send_command(svp_pkg::CMD_HOME, 16'sh0000, 1'b0, 1'b0, 1'b0);
		send_command(svp_pkg::CMD_TICK, 16'sh0000, 1'b0, 1'b0, 1'b0);
	endtask

	function automatic svp_pkg::cfg_t pick_settings(int phase_no);
		svp_pkg::cfg_t c;
		c.step_interval = ($urandom_range(0, 2) == 0) ? 8'd1 : 8'($urandom_range(2, 12));
		case ($urandom_range(0, 15))
			0:       c.step_interval = 8'd0;
			1:       c.step_interval = 8'd255;
			default: ;
		endcase
		c.home_steps = 10'($urandom_range(0, 16));
		case ($urandom_range(0, 5))
			0:       c.max_position = 10'd0;
			1:       c.max_position = 10'd1023;
			default: c.max_position = 10'($urandom_range(1, 80));
		endcase
		c.park_position = $urandom_range(0, 1) ? 10'($urandom) : 10'($urandom_range(0, 90));
		c.start_target  = $urandom_range(0, 1) ? 10'($urandom) : 10'($urandom_range(0, 90));
		c.ac_bump       = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
		c.steering_bump = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
		c.drive_bump    = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
		case (phase_no)
			PHASE_LOW_CORNER:
				c = '{step_interval: 8'd0, home_steps: 10'd0, max_position: 10'd1,
					park_position: 10'd0, start_target: 10'd0, ac_bump: 8'd0,
					steering_bump: 8'd0, drive_bump: 8'd0};
			PHASE_HIGH_CORNER:
				c = '{step_interval: 8'd255, home_steps: 10'd1, max_position: 10'd1023,
					park_position: 10'd1023, start_target: 10'd1023, ac_bump: 8'd255,
					steering_bump: 8'd255, drive_bump: 8'd255};
			PHASE_LONG_HOME: begin
				c.step_interval = 8'd0;
				c.home_steps    = 10'd1023;
			end
			default: ;
		endcase
		return c;
	endfunction

	// Phases of random settings, each with mostly ticks and a mix of commands
	task automatic test_random_traffic();
		int                 done_items;
		int                 phase_no;
		int                 phase_len;
		int                 sel;
		logic [2:0]         cmd;
		logic [2:0]         loads;
		logic signed [15:0] value;
		done_items = 0;
		phase_no   = 0;
		while (done_items < RANDOM_ITEMS) begin
			apply_config(pick_settings(phase_no));
			phase_len = $urandom_range(80, 220);
			if (phase_no == PHASE_LONG_HOME) begin
				send_command(svp_pkg::CMD_HOME, 16'sh0000, 1'b0, 1'b0, 1'b0);
				done_items++;
			end
			if (phase_len > RANDOM_ITEMS - done_items)
				phase_len = RANDOM_ITEMS - done_items;
			repeat (phase_len) begin
				sel   = $urandom_range(0, 99);
				loads = 3'($urandom);
				value = 16'($urandom);
				if (home_run)
					cmd = (sel < 85) ? svp_pkg::CMD_TICK : 3'($urandom);
				else if (sel < 55)
					cmd = svp_pkg::CMD_TICK;
				else if (sel < 72) begin
					cmd = svp_pkg::CMD_SET;
					if (sel < 64)
						value = 16'($urandom_range(0, int'(valve_cfg.max_position) + 4));
				end else if (sel < 77)
					cmd = svp_pkg::CMD_PARK;
				else if (sel < 90)
					cmd = svp_pkg::CMD_COMP;
				else if (sel < 94)
					cmd = svp_pkg::CMD_HOME;
				else
					cmd = CMD_RSVD_A + 3'($urandom_range(0, 2));
				done_items++;
				send_command(cmd, value, loads[2], loads[1], loads[0]);
			end
			// Finish the long homing run at the fast interval so later phases step
			if (phase_no == PHASE_LONG_HOME) begin
				while (home_run && done_items < RANDOM_ITEMS) begin
					done_items++;
					send_command(svp_pkg::CMD_TICK, 16'sh0000, 1'b0, 1'b0, 1'b0);
				end
			end
			phase_no++;
		end
	endtask

	initial begin
		valve_cfg = '{step_interval: svp_pkg::RST_STEP_INTERVAL,
			home_steps: svp_pkg::RST_HOME_STEPS,
			max_position: svp_pkg::RST_MAX_POSITION,
			park_position: svp_pkg::RST_PARK_POSITION,
			start_target: svp_pkg::RST_START_TARGET, ac_bump: 8'd0, steering_bump: 8'd0,
			drive_bump: 8'd0};
		phase_ix   = '0;
		pos_now    = '0;
		tgt_now    = '0;
		tick_count = '0;
		home_left  = '0;
		home_run   = 1'b0;
		coil_now   = svp_pkg::COILS_OFF;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_commands();
		test_load_compensation();
		test_homing();
		test_random_traffic();
		settle_block();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#(RUN_LIMIT_NS);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
